### sv/bisection_linear_interpolator_core_defines.svh
// Assertion macros used by the bisection interpolator core.
`ifndef BISECTION_LINEAR_INTERPOLATOR_CORE_DEFINES_SVH
`define BISECTION_LINEAR_INTERPOLATOR_CORE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define BLI_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define BLI_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/bli_pkg.sv
// Shared types and constants of the bisection interpolator.
package bli_pkg;

  localparam int unsigned FIELD_W = 16;

  typedef logic signed [FIELD_W-1:0] field_t;

  // Control that travels down the pipeline alongside each item.
  typedef struct packed {
    logic valid;
    logic ascending;
  } ctl_t;

endpackage

### sv/bli_entry.sv
// Entry stage: loads the operands, classifies the segment and applies the clamp.
module bli_entry #(
  parameter int unsigned W = 16
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic            valid_i,
  input  bli_pkg::field_t query_x_i,
  input  bli_pkg::field_t start_x_i,
  input  bli_pkg::field_t end_x_i,
  input  bli_pkg::field_t start_y_i,
  input  bli_pkg::field_t end_y_i,
  output bli_pkg::ctl_t   ctl_o,
  output logic signed [W-1:0] x_o,
  output logic signed [W-1:0] xs_o,
  output logic signed [W-1:0] xe_o,
  output logic signed [W-1:0] ys_o,
  output logic signed [W-1:0] ye_o
);
  import bli_pkg::*;

  logic signed [W-1:0] x, xs, xe, ys, ye;
  logic                asc, pick_end, pick_start;
  ctl_t                ctl_d, ctl_q;
  logic signed [W-1:0] x_d, x_q, xs_d, xs_q, xe_d, xe_q, ys_d, ys_q, ye_d, ye_q;

  always_comb begin
    x  = $signed(query_x_i[W-1:0]);
    xs = $signed(start_x_i[W-1:0]);
    xe = $signed(end_x_i[W-1:0]);
    ys = $signed(start_y_i[W-1:0]);
    ye = $signed(end_y_i[W-1:0]);
    asc = xe > xs;
    pick_end   = asc ? (x > xe) : (x < xe);
    pick_start = asc ? (x < xs) : (x > xs);

    ctl_d.valid     = valid_i;
    ctl_d.ascending = asc;
    x_d  = x;
    xs_d = xs;
    xe_d = xe;
    ys_d = ys;
    ye_d = ye;
    // A clamped query collapses the segment onto x, so no halving step moves it
    // and the final pick returns the start y, which then holds the clamp value.
    if (pick_end || pick_start) begin
      xs_d = x;
      xe_d = x;
      ys_d = pick_end ? ye : ys;
      ye_d = pick_end ? ye : ys;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else if (en_i) begin
      ctl_q <= ctl_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q  <= x_d;
      xs_q <= xs_d;
      xe_q <= xe_d;
      ys_q <= ys_d;
      ye_q <= ye_d;
    end
  end

  assign ctl_o = ctl_q;
  assign x_o   = x_q;
  assign xs_o  = xs_q;
  assign xe_o  = xe_q;
  assign ys_o  = ys_q;
  assign ye_o  = ye_q;

endmodule

### sv/bli_halve_stage.sv
// One registered halving step of the bisection.
module bli_halve_stage #(
  parameter int unsigned W = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  bli_pkg::ctl_t       ctl_i,
  input  logic signed [W-1:0] x_i,
  input  logic signed [W-1:0] xs_i,
  input  logic signed [W-1:0] xe_i,
  input  logic signed [W-1:0] ys_i,
  input  logic signed [W-1:0] ye_i,
  output bli_pkg::ctl_t       ctl_o,
  output logic signed [W-1:0] x_o,
  output logic signed [W-1:0] xs_o,
  output logic signed [W-1:0] xe_o,
  output logic signed [W-1:0] ys_o,
  output logic signed [W-1:0] ye_o
);
  import bli_pkg::*;

  localparam int unsigned W1 = W + 1;
  localparam logic signed [W:0] SpanOne    = W1'(1);
  localparam logic signed [W:0] SpanMinOne = -SpanOne;

  logic signed [W:0]   span, dx, dyd, dy, off;
  logic                wide, move_start;
  ctl_t                ctl_q;
  logic signed [W-1:0] x_q, xs_d, xs_q, xe_d, xe_q, ys_d, ys_q, ye_d, ye_q;

  always_comb begin
    // Differences are one bit wider than the operands so they never wrap.
    span = W1'(xe_i) - W1'(xs_i);
    dyd  = W1'(ye_i) - W1'(ys_i);
    off  = W1'(x_i) - W1'(xs_i);
    dx   = span >>> 1;
    dy   = dyd >>> 1;
    wide = ctl_i.ascending ? (span > SpanOne) : (span < SpanMinOne);
    move_start = ctl_i.ascending ? (off > dx) : (off <= dx);

    xs_d = xs_i;
    xe_d = xe_i;
    ys_d = ys_i;
    ye_d = ye_i;
    // The new ends always lie between the old ones, so W bits suffice.
    if (wide) begin
      if (move_start) begin
        xs_d = xs_i + W'(dx);
        ys_d = ys_i + W'(dy);
      end else begin
        xe_d = xe_i - W'(dx);
        ye_d = ye_i - W'(dy);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else if (en_i) begin
      ctl_q <= ctl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q  <= x_i;
      xs_q <= xs_d;
      xe_q <= xe_d;
      ys_q <= ys_d;
      ye_q <= ye_d;
    end
  end

  assign ctl_o = ctl_q;
  assign x_o   = x_q;
  assign xs_o  = xs_q;
  assign xe_o  = xe_q;
  assign ys_o  = ys_q;
  assign ye_o  = ye_q;

endmodule

### sv/bisection_linear_interpolator_core.sv
// Bisection linear interpolator: a pipeline of one entry stage, one halving
// stage per data bit and an output register. It accepts one transfer per clock
// cycle while the output is not stalled and returns results in order. The
// halving stages are as many as the x span needs to shrink to at most one.
// A stall on the output freezes the whole pipeline at once, so nothing is lost
// or repeated.
`include "bisection_linear_interpolator_core_defines.svh"

module bisection_linear_interpolator_core #(
  parameter int unsigned WIDTH = 16
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  bli_pkg::field_t query_x_i,
  input  bli_pkg::field_t start_x_i,
  input  bli_pkg::field_t end_x_i,
  input  bli_pkg::field_t start_y_i,
  input  bli_pkg::field_t end_y_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output bli_pkg::field_t result_y_o
);
  import bli_pkg::*;

  localparam int unsigned N = (WIDTH < FIELD_W) ? WIDTH : FIELD_W;

  logic                en;
  ctl_t                ctl_s [N+1];
  logic signed [N-1:0] x_s  [N+1];
  logic signed [N-1:0] xs_s [N+1];
  logic signed [N-1:0] xe_s [N+1];
  logic signed [N-1:0] ys_s [N+1];
  logic signed [N-1:0] ye_s [N+1];
  logic                out_valid_q;
  logic signed [N-1:0] res_d, res_q;

  assign en         = !out_valid_q || out_ready_i;
  assign in_ready_o = en;

  bli_entry #(.W(N)) u_entry (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (en),
    .valid_i   (in_valid_i),
    .query_x_i (query_x_i),
    .start_x_i (start_x_i),
    .end_x_i   (end_x_i),
    .start_y_i (start_y_i),
    .end_y_i   (end_y_i),
    .ctl_o     (ctl_s[0]),
    .x_o       (x_s[0]),
    .xs_o      (xs_s[0]),
    .xe_o      (xe_s[0]),
    .ys_o      (ys_s[0]),
    .ye_o      (ye_s[0])
  );

  for (genvar k = 0; k < N; k++) begin : g_halve
    bli_halve_stage #(.W(N)) u_stage (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .ctl_i  (ctl_s[k]),
      .x_i    (x_s[k]),
      .xs_i   (xs_s[k]),
      .xe_i   (xe_s[k]),
      .ys_i   (ys_s[k]),
      .ye_i   (ye_s[k]),
      .ctl_o  (ctl_s[k+1]),
      .x_o    (x_s[k+1]),
      .xs_o   (xs_s[k+1]),
      .xe_o   (xe_s[k+1]),
      .ys_o   (ys_s[k+1]),
      .ye_o   (ye_s[k+1])
    );
  end

  assign res_d = (x_s[N] == xs_s[N]) ? ys_s[N] : ye_s[N];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= ctl_s[N].valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign result_y_o  = FIELD_W'(res_q);

  // After the last halving step the query must sit on one of the two ends.
  `BLI_ASSERT_IMP(a_converged, clk_i, rst_ni, ctl_s[N].valid, (x_s[N] == xs_s[N]) || (x_s[N] == xe_s[N]), "bisection did not converge onto the query")
  // A stalled output must freeze the last halving stage.
  `BLI_ASSERT_NXT(a_stall_holds, clk_i, rst_ni, out_valid_q && !out_ready_i, $stable(ctl_s[N]) && $stable(xs_s[N]) && $stable(ys_s[N]), "pipeline moved during a stall")
  // An item leaving the last stage while the pipeline advances must appear at the output.
  `BLI_ASSERT_NXT(a_no_drop, clk_i, rst_ni, en && ctl_s[N].valid, out_valid_o, "item lost between last stage and output")

endmodule
